FILE: design/acc_pkg.sv
// Shared types, codes and constants of the crossfade curve block.
package acc_pkg;

  localparam int CHANNELS = 4;

  typedef logic [2:0] curve_t;
  localparam curve_t CURVE_LINEAR   = 3'd0;
  localparam curve_t CURVE_SMOOTH   = 3'd1;
  localparam curve_t CURVE_EQPOW    = 3'd2;
  localparam curve_t CURVE_OUTIN    = 3'd3;
  localparam curve_t CURVE_EASE_IN  = 3'd4;
  localparam curve_t CURVE_EASE_OUT = 3'd5;

  localparam int REG_INDEX_W = 2;
  localparam int REG_DATA_W  = 24;
  typedef logic [REG_INDEX_W-1:0] reg_index_t;
  localparam reg_index_t REG_CURVE    = 2'd0;
  localparam reg_index_t REG_LENGTH   = 2'd1;
  localparam reg_index_t REG_STEP     = 2'd2;
  localparam reg_index_t REG_CHANNELS = 2'd3;

  localparam int FRAME_W = 24;
  localparam int STEP_W  = 24;
  typedef logic [FRAME_W-1:0] frames_t;

  // equal-power polynomial, Q2.30
  localparam int HORNER_W    = 32;
  localparam int HORNER_FRAC = 30;
  typedef logic signed [HORNER_W-1:0] horner_t;
  localparam horner_t EQP_ONE = 32'sh4000_0000;
  localparam horner_t EQP_A   = 32'sd362283724;
  localparam horner_t EQP_B   = -32'sd1432734592;
  localparam horner_t EQP_C   = -EQP_ONE - EQP_A - EQP_B;

  typedef struct packed {
    curve_t     curve;
    logic [2:0] active;
    logic       finished;
    logic       last_frame;
  } fade_status_t;

endpackage

FILE: design/acc_if.sv
// Channel interfaces: frame input, mixed output and register writes.
interface acc_frame_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] old_sample_0;
  logic signed [SAMPLE_BITS-1:0] old_sample_1;
  logic signed [SAMPLE_BITS-1:0] old_sample_2;
  logic signed [SAMPLE_BITS-1:0] old_sample_3;
  logic signed [SAMPLE_BITS-1:0] new_sample_0;
  logic signed [SAMPLE_BITS-1:0] new_sample_1;
  logic signed [SAMPLE_BITS-1:0] new_sample_2;
  logic signed [SAMPLE_BITS-1:0] new_sample_3;

  modport source (output valid, output old_sample_0, output old_sample_1,
                  output old_sample_2, output old_sample_3, output new_sample_0,
                  output new_sample_1, output new_sample_2, output new_sample_3,
                  input ready);
  modport sink (input valid, input old_sample_0, input old_sample_1,
                input old_sample_2, input old_sample_3, input new_sample_0,
                input new_sample_1, input new_sample_2, input new_sample_3,
                output ready);
endinterface

interface acc_mix_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mixed_0;
  logic signed [SAMPLE_BITS-1:0] mixed_1;
  logic signed [SAMPLE_BITS-1:0] mixed_2;
  logic signed [SAMPLE_BITS-1:0] mixed_3;
  logic                          fade_done;

  modport source (output valid, output mixed_0, output mixed_1, output mixed_2,
                  output mixed_3, output fade_done, input ready);
  modport sink (input valid, input mixed_0, input mixed_1, input mixed_2,
                input mixed_3, input fade_done, output ready);
endinterface

interface acc_cfg_if import acc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  reg_index_t            index;
  logic [REG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/acc_mul.sv
// Shared signed multiplier with registered product and selectable scaling shift.
module acc_mul import acc_pkg::*; #(
  parameter int MUL_W         = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [MUL_W-1:0]   op_a,
  input  logic signed [MUL_W-1:0]   op_b,
  input  logic                      q30,
  output logic signed [2*MUL_W-1:0] result
);

  logic signed [2*MUL_W-1:0] prod;
  logic                      q30_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      q30_r <= 1'b0;
    end else begin
      q30_r <= q30;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // floor scaling: Q.30 for the polynomial, Q.F otherwise
  assign result = q30_r ? (prod >>> HORNER_FRAC) : (prod >>> FRACTION_BITS);

endmodule

FILE: design/acc_cfg.sv
// Register file and fade state: curve, channels, step, position and frame count.
module acc_cfg import acc_pkg::*; #(
  parameter int FRACTION_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  acc_cfg_if.sink                cfg,
  input  logic                   advance,
  output fade_status_t           status,
  output logic [FRACTION_BITS:0] position
);

  localparam int SUM_W = ((FRACTION_BITS + 1 > STEP_W) ? FRACTION_BITS + 1 : STEP_W) + 1;
  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [STEP_W-1:0] STEP_RESET = 24'h80_0000;

  curve_t            curve;
  logic [2:0]        active;
  logic [STEP_W-1:0] ramp_step;
  frames_t           frames_left;
  logic              finished;
  logic [SUM_W-1:0]  pos_sum;

  assign cfg.ready = 1'b1;
  assign pos_sum = SUM_W'(position) + SUM_W'(ramp_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      curve       <= CURVE_LINEAR;
      active      <= 3'd4;
      ramp_step   <= STEP_RESET;
      frames_left <= FRAME_W'(1);
      position    <= '0;
      finished    <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CURVE: begin
          curve <= cfg.data[2:0];
        end
        REG_LENGTH: begin
          frames_left <= cfg.data[FRAME_W-1:0];
          position    <= '0;
          finished    <= 1'b0;
        end
        REG_STEP: begin
          ramp_step <= cfg.data[STEP_W-1:0];
        end
        REG_CHANNELS: begin
          active <= cfg.data[2:0];
        end
      endcase
    end else if (advance && !finished) begin
      if (frames_left <= FRAME_W'(1)) begin
        frames_left <= '0;
        finished    <= 1'b1;
      end else begin
        frames_left <= frames_left - FRAME_W'(1);
        if (pos_sum > SUM_W'(ONE)) begin
          position <= ONE;
        end else begin
          position <= pos_sum[FRACTION_BITS:0];
        end
      end
    end
  end

  assign status.curve      = curve;
  assign status.active     = active;
  assign status.finished   = finished;
  assign status.last_frame = (frames_left <= FRAME_W'(1));

endmodule

FILE: design/audio_crossfader_curves.sv
// Crossfade curve generator top level: sequencer around one shared multiplier.
//
//  port     dir   carries
//  cfg      in    register writes: index, data
//  samples  in    one frame: old_sample_0..3, new_sample_0..3
//  mixed    out   one frame: mixed_0..3, fade_done
//
// Per frame, the weights are computed first (none for linear or after the fade), then
// each channel: one product, or two for equal power. An inactive channel, or any channel
// after the fade, takes no product. All products go through the one multiplier, weights
// first, then channel by channel.
// Reset is synchronous; registers return to curve 0, length 1, half step, 4 ch.
// A finished frame waits in the output register while the next one is taken.
module audio_crossfader_curves import acc_pkg::*; #(
  parameter int SAMPLE_BITS   = 24,
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  acc_cfg_if.sink     cfg,
  acc_frame_if.sink   samples,
  acc_mix_if.source   mixed
);

  localparam int MUL_W =
    (HORNER_W > FRACTION_BITS + 3) ?
      ((HORNER_W > SAMPLE_BITS + 1) ? HORNER_W : SAMPLE_BITS + 1) :
      ((FRACTION_BITS + 3 > SAMPLE_BITS + 1) ? FRACTION_BITS + 3 : SAMPLE_BITS + 1);
  localparam int ACC_W  = SAMPLE_BITS + 2;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int CH_W   = $clog2(CHANNELS);
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
  localparam logic [FRACTION_BITS:0]   ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [FRACTION_BITS+1:0] ONE2 = {2'b01, {FRACTION_BITS{1'b0}}};
  localparam logic [FRACTION_BITS+1:0] ONE3 = {2'b11, {FRACTION_BITS{1'b0}}};
  localparam horner_t ONE_H = HORNER_W'(ONE);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WMUL = 4'd1;
  localparam logic [3:0] S_WACC = 4'd2;
  localparam logic [3:0] S_CH   = 4'd3;
  localparam logic [3:0] S_PM1  = 4'd4;
  localparam logic [3:0] S_PA1  = 4'd5;
  localparam logic [3:0] S_PM2  = 4'd6;
  localparam logic [3:0] S_PA2  = 4'd7;
  localparam logic [3:0] S_ADV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > ACC_MAX) begin
      r = ACC_MAX[SAMPLE_BITS-1:0];
    end else if (v < ACC_MIN) begin
      r = ACC_MIN[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  fade_status_t           st;
  logic [FRACTION_BITS:0] x;
  logic                   advance;

  logic [3:0]             state;
  logic [2:0]             wstep;
  logic [CH_W-1:0]        ch;
  logic [FRACTION_BITS:0] w;
  logic [FRACTION_BITS:0] w2;
  horner_t                t;
  logic signed [ACC_W-1:0] acc;

  logic signed [SAMPLE_BITS-1:0] a_reg [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] b_reg [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] res [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] out_mix [CHANNELS];
  logic                          out_done;
  logic                          out_valid;

  logic signed [MUL_W-1:0]   op_a;
  logic signed [MUL_W-1:0]   op_b;
  logic                      q30;
  logic signed [2*MUL_W-1:0] mres;

  logic                          lower;
  logic [FRACTION_BITS+1:0]      x2;
  logic [FRACTION_BITS+1:0]      u_lo;
  logic [FRACTION_BITS+1:0]      u_hi;
  logic [FRACTION_BITS:0]        u;
  logic [FRACTION_BITS+1:0]      u3;
  logic [FRACTION_BITS:0]        v;
  logic [HORNER_W-1:0]           v30;
  logic [1:0]                    hk;
  horner_t                       horner_add;
  horner_t                       t_sum;
  horner_t                       t_q;
  logic [FRACTION_BITS:0]        w_clamp;
  logic                          need_wt;
  logic [2:0]                    last_wstep;
  logic signed [SAMPLE_BITS-1:0] a_cur;
  logic signed [SAMPLE_BITS-1:0] b_cur;
  logic signed [DIFF_W-1:0]      op1;
  logic signed [ACC_W-1:0]       base;
  logic signed [ACC_W-1:0]       prod_acc;
  logic signed [ACC_W-1:0]       acc1;
  logic signed [ACC_W-1:0]       acc2;

  acc_cfg #(.FRACTION_BITS(FRACTION_BITS)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .advance  (advance),
    .status   (st),
    .position (x)
  );

  acc_mul #(.MUL_W(MUL_W), .FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .op_a   (op_a),
    .op_b   (op_b),
    .q30    (q30),
    .result (mres)
  );

  assign advance = (state == S_ADV);
  assign samples.ready = (state == S_IDLE);

  // curve argument
  assign lower = (x[FRACTION_BITS:FRACTION_BITS-1] == 2'b00);
  assign x2    = {x, 1'b0};
  assign u_lo  = ONE2 - x2;
  assign u_hi  = x2 - ONE2;
  assign u3    = ONE3 - {u, 1'b0};

  always_comb begin
    unique case (st.curve)
      CURVE_OUTIN:    u = lower ? u_lo[FRACTION_BITS:0] : u_hi[FRACTION_BITS:0];
      CURVE_EASE_OUT: u = ONE - x;
      default:        u = x;
    endcase
  end

  assign need_wt = (st.curve == CURVE_SMOOTH) || (st.curve == CURVE_EQPOW) ||
                   (st.curve == CURVE_OUTIN) || (st.curve == CURVE_EASE_IN) ||
                   (st.curve == CURVE_EASE_OUT);
  assign last_wstep = (st.curve == CURVE_EQPOW) ? 3'd5 : 3'd1;

  // equal-power Horner steps: p(1-x) then p(x)
  assign v   = (wstep < 3'd3) ? ONE - x : x;
  assign v30 = HORNER_W'(v) << (HORNER_FRAC - FRACTION_BITS);
  assign hk  = (wstep < 3'd3) ? wstep[1:0] : 2'(wstep - 3'd3);

  always_comb begin
    unique case (hk)
      2'd0:    horner_add = EQP_B;
      2'd1:    horner_add = EQP_C;
      default: horner_add = EQP_ONE;
    endcase
  end

  assign t_sum = $signed(mres[HORNER_W-1:0]) + horner_add;
  assign t_q   = t_sum >>> (HORNER_FRAC - FRACTION_BITS);

  always_comb begin
    if (t_q[HORNER_W-1]) begin
      w_clamp = '0;
    end else if (t_q > ONE_H) begin
      w_clamp = ONE;
    end else begin
      w_clamp = t_q[FRACTION_BITS:0];
    end
  end

  // per-channel operands
  assign a_cur = a_reg[ch];
  assign b_cur = b_reg[ch];

  always_comb begin
    unique case (st.curve)
      CURVE_EQPOW: begin
        op1  = DIFF_W'(a_cur);
        base = '0;
      end
      CURVE_OUTIN: begin
        op1  = lower ? DIFF_W'(a_cur) : DIFF_W'(b_cur);
        base = '0;
      end
      CURVE_EASE_OUT: begin
        op1  = DIFF_W'(a_cur) - DIFF_W'(b_cur);
        base = ACC_W'(b_cur);
      end
      default: begin
        op1  = DIFF_W'(b_cur) - DIFF_W'(a_cur);
        base = ACC_W'(a_cur);
      end
    endcase
  end

  assign prod_acc = $signed(mres[ACC_W-1:0]);
  assign acc1     = base + prod_acc;
  assign acc2     = acc + prod_acc;

  always_comb begin
    op_a = '0;
    op_b = '0;
    q30  = 1'b0;
    unique case (state)
      S_WMUL: begin
        if (st.curve == CURVE_EQPOW) begin
          q30  = 1'b1;
          op_a = MUL_W'(v30);
          op_b = (hk == 2'd0) ? MUL_W'(EQP_A) : MUL_W'(t);
        end else if (wstep == 3'd0) begin
          op_a = MUL_W'(u);
          op_b = MUL_W'(u);
        end else begin
          op_a = MUL_W'(w);
          if ((st.curve == CURVE_SMOOTH) || (st.curve == CURVE_OUTIN)) begin
            op_b = MUL_W'(u3);
          end else begin
            op_b = MUL_W'(u);
          end
        end
      end
      S_PM1: begin
        op_a = MUL_W'(w);
        op_b = MUL_W'(op1);
      end
      S_PM2: begin
        op_a = MUL_W'(w2);
        op_b = MUL_W'(b_cur);
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wstep     <= '0;
      ch        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (mixed.valid && mixed.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            a_reg[0] <= samples.old_sample_0;
            a_reg[1] <= samples.old_sample_1;
            a_reg[2] <= samples.old_sample_2;
            a_reg[3] <= samples.old_sample_3;
            b_reg[0] <= samples.new_sample_0;
            b_reg[1] <= samples.new_sample_1;
            b_reg[2] <= samples.new_sample_2;
            b_reg[3] <= samples.new_sample_3;
            wstep    <= '0;
            ch       <= '0;
            w        <= x;
            state    <= (need_wt && !st.finished) ? S_WMUL : S_CH;
          end
        end
        S_WMUL: begin
          state <= S_WACC;
        end
        S_WACC: begin
          if (st.curve == CURVE_EQPOW) begin
            if (hk == 2'd2) begin
              if (wstep < 3'd3) begin
                w <= w_clamp;
              end else begin
                w2 <= w_clamp;
              end
            end else begin
              t <= t_sum;
            end
          end else begin
            w <= mres[FRACTION_BITS:0];
          end
          if (wstep == last_wstep) begin
            state <= S_CH;
          end else begin
            wstep <= wstep + 3'd1;
            state <= S_WMUL;
          end
        end
        S_CH: begin
          if (3'(ch) >= st.active || st.finished) begin
            res[ch] <= (3'(ch) >= st.active) ? '0 : b_cur;
            if (ch == LAST_CH) begin
              state <= S_ADV;
            end else begin
              ch <= ch + CH_W'(1);
            end
          end else begin
            state <= S_PM1;
          end
        end
        S_PM1: begin
          state <= S_PA1;
        end
        S_PA1: begin
          if (st.curve == CURVE_EQPOW) begin
            acc   <= acc1;
            state <= S_PM2;
          end else begin
            res[ch] <= sat(acc1);
            if (ch == LAST_CH) begin
              state <= S_ADV;
            end else begin
              ch    <= ch + CH_W'(1);
              state <= S_CH;
            end
          end
        end
        S_PM2: begin
          state <= S_PA2;
        end
        S_PA2: begin
          res[ch] <= sat(acc2);
          if (ch == LAST_CH) begin
            state <= S_ADV;
          end else begin
            ch    <= ch + CH_W'(1);
            state <= S_CH;
          end
        end
        S_ADV: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || mixed.ready) begin
            out_mix   <= res;
            out_done  <= st.finished;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign mixed.valid     = out_valid;
  assign mixed.mixed_0   = out_mix[0];
  assign mixed.mixed_1   = out_mix[1];
  assign mixed.mixed_2   = out_mix[2];
  assign mixed.mixed_3   = out_mix[3];
  assign mixed.fade_done = out_done;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> !samples.ready)
    else $error("frame taken while previous frame still in work");

  a_advance_after_last_channel: assert property (@(posedge clk) disable iff (rst)
    advance |-> (ch == LAST_CH))
    else $error("fade state advanced before all channels were mixed");

  a_finish_on_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(st.finished) |-> $past(advance))
    else $error("fade finished without a frame transaction");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for audio_crossfader_curves: predicts each mixed frame and compares.
module tb import acc_pkg::*; ();

  localparam longint UNITY       = 64'sd1 <<< 24;
  localparam longint Q30_ONE     = 64'sd1 <<< 30;
  localparam longint EQ_A        = 64'sd362283724;
  localparam longint EQ_B        = -64'sd1432734592;
  localparam longint EQ_C        = -Q30_ONE - EQ_A - EQ_B;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     RANDOM_FRAMES = 580;
  localparam logic [5:0][23:0] CORNERS = {24'h7FFFFF, 24'h800000, 24'h000000,
                                          24'hFFFFFF, 24'h000001, 24'h400000};

  typedef struct packed {
    logic [3:0][23:0] old_s;
    logic [3:0][23:0] new_s;
  } frame_t;

  typedef struct packed {
    logic [3:0][23:0] mix;
    logic             done;
  } mix_result_t;

  logic clk = 1'b0;
  logic rst;

  acc_cfg_if        cfg_ch ();
  acc_frame_if #(24) frame_ch ();
  acc_mix_if #(24)   mix_ch ();

  audio_crossfader_curves dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (frame_ch),
    .mixed   (mix_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register copy
  curve_t      sel_curve;
  frames_t     frames_rem;
  logic [23:0] ramp;
  logic [2:0]  chans;
  logic [24:0] fade_pos;
  bit          finished;

  frame_t      frame_backlog [$];
  mix_result_t expected_mixes [$];

  int   mismatches;
  int   frames_taken;
  int   mixes_checked;
  int   reg_writes;
  int   directed_frames;
  int   random_frames;
  int   cycle_count;
  bit [7:0] curves_used;

  int   send_mode;
  int   stall_mode;
  int   burst_left;
  int   gap_left;
  int   hold_left;
  int   rx_tick;
  bit   hold_request;

  frame_t      next_frame;
  frame_t      seen_frame;
  mix_result_t got_mix;
  mix_result_t want_mix;

  function automatic longint q_mul(longint a, longint b);
    return (a * b) >>> 24;
  endfunction

  function automatic longint smooth_gain(longint x);
    return q_mul(q_mul(x, x), 3 * UNITY - 2 * x);
  endfunction

  function automatic longint cube_gain(longint x);
    return q_mul(q_mul(x, x), x);
  endfunction

  // equal-power polynomial in Q2.30, Horner steps floor
  function automatic longint eq_gain(longint x);
    longint x30;
    longint t;
    x30 = x <<< 6;
    t = EQ_B + ((x30 * EQ_A) >>> 30);
    t = EQ_C + ((x30 * t) >>> 30);
    t = Q30_ONE + ((x30 * t) >>> 30);
    t = t >>> 6;
    return (t < 0) ? 0 : ((t > UNITY) ? UNITY : t);
  endfunction

  function automatic longint scale(longint w, longint s);
    return (w * s) >>> 24;
  endfunction

  function automatic longint clamp24(longint v);
    return (v > 64'sd8388607) ? 64'sd8388607 : ((v < -64'sd8388608) ? -64'sd8388608 : v);
  endfunction

  function automatic longint curve_blend(longint x, longint a, longint b);
    case (sel_curve)
      CURVE_SMOOTH:   return a + scale(smooth_gain(x), b - a);
      CURVE_EQPOW:    return scale(eq_gain(UNITY - x), a) + scale(eq_gain(x), b);
      CURVE_OUTIN:    return (2 * x < UNITY) ? scale(smooth_gain(UNITY - 2 * x), a)
                                             : scale(smooth_gain(2 * x - UNITY), b);
      CURVE_EASE_IN:  return a + scale(cube_gain(x), b - a);
      CURVE_EASE_OUT: return b + scale(cube_gain(UNITY - x), a - b);
      default:        return a + scale(x, b - a);
    endcase
  endfunction

  function automatic mix_result_t crossfade_predict(frame_t f);
    mix_result_t r;
    int used;
    longint a;
    longint b;
    longint v;
    used = (chans > CHANNELS) ? CHANNELS : int'(chans);
    for (int i = 0; i < CHANNELS; i++) begin
      v = 0;
      if (i < used) begin
        a = $signed(f.old_s[i]);
        b = $signed(f.new_s[i]);
        v = finished ? b : clamp24(curve_blend(longint'(fade_pos), a, b));
      end
      r.mix[i] = v[23:0];
    end
    if (!finished) begin
      if (frames_rem <= 1) begin
        frames_rem = '0;
        finished = 1'b1;
      end else begin
        frames_rem = frames_rem - 1'b1;
        v = longint'(fade_pos) + longint'(ramp);
        fade_pos = 25'((v > UNITY) ? UNITY : v);
      end
    end
    r.done = finished;
    return r;
  endfunction

  function automatic void apply_reg(reg_index_t idx, logic [23:0] d);
    case (idx)
      REG_CURVE:    sel_curve = d[2:0];
      REG_LENGTH: begin
        frames_rem = d;
        fade_pos = '0;
        finished = 1'b0;
      end
      REG_STEP:     ramp = d;
      REG_CHANNELS: chans = d[2:0];
      default: ;
    endcase
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // monitor: register writes, result checks, then new frames
  always @(posedge clk) begin
    if (rst) begin
      sel_curve = CURVE_LINEAR;
      frames_rem = 24'd1;
      ramp = 24'h800000;
      chans = 3'd4;
      fade_pos = '0;
      finished = 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_reg(cfg_ch.index, cfg_ch.data);
        reg_writes++;
      end
      if (mix_ch.valid && mix_ch.ready) begin
        got_mix.mix = {mix_ch.mixed_3, mix_ch.mixed_2, mix_ch.mixed_1, mix_ch.mixed_0};
        got_mix.done = mix_ch.fade_done;
        if (expected_mixes.size() == 0) begin
          report($sformatf("result transaction with none pending: mixed_0 %0d done %0b",
                           $signed(got_mix.mix[0]), got_mix.done));
        end else begin
          want_mix = expected_mixes.pop_front();
          for (int i = 0; i < CHANNELS; i++) begin
            if (want_mix.mix[i] !== got_mix.mix[i])
              report($sformatf("result %0d mixed_%0d: expected %0d got %0d", mixes_checked, i,
                               $signed(want_mix.mix[i]), $signed(got_mix.mix[i])));
          end
          if (want_mix.done !== got_mix.done)
            report($sformatf("result %0d fade_done: expected %0b got %0b", mixes_checked,
                             want_mix.done, got_mix.done));
          mixes_checked++;
        end
      end
      if (frame_ch.valid && frame_ch.ready) begin
        seen_frame.old_s = {frame_ch.old_sample_3, frame_ch.old_sample_2,
                            frame_ch.old_sample_1, frame_ch.old_sample_0};
        seen_frame.new_s = {frame_ch.new_sample_3, frame_ch.new_sample_2,
                            frame_ch.new_sample_1, frame_ch.new_sample_0};
        curves_used[sel_curve] = 1'b1;
        expected_mixes.insert(expected_mixes.size(), crossfade_predict(seen_frame));
        frames_taken++;
      end
    end
  end

  // frame driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.valid <= 1'b0;
    end else if (!frame_ch.valid || frame_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        frame_ch.valid <= 1'b0;
      end else if (frame_backlog.size() > 0) begin
        next_frame = frame_backlog.pop_front();
        frame_ch.old_sample_0 <= next_frame.old_s[0];
        frame_ch.old_sample_1 <= next_frame.old_s[1];
        frame_ch.old_sample_2 <= next_frame.old_s[2];
        frame_ch.old_sample_3 <= next_frame.old_s[3];
        frame_ch.new_sample_0 <= next_frame.new_s[0];
        frame_ch.new_sample_1 <= next_frame.new_s[1];
        frame_ch.new_sample_2 <= next_frame.new_s[2];
        frame_ch.new_sample_3 <= next_frame.new_s[3];
        frame_ch.valid <= 1'b1;
        if (send_mode != 0) begin
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 6);
          end
        end
      end else begin
        frame_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: stall pattern per phase, plus one long hold on request
  always @(posedge clk) begin
    rx_tick++;
    if (rst) begin
      mix_ch.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
      mix_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      mix_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        1: mix_ch.ready <= ($urandom_range(0, 9) < 7);
        2: mix_ch.ready <= ((rx_tick % 11) > 3);
        3: mix_ch.ready <= ($urandom_range(0, 9) < 2);
        default: mix_ch.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_mixes.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [23:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (frame_backlog.size() != 0 || frame_ch.valid || expected_mixes.size() != 0);
  endtask

  // one phase: drain, reprogram the registers in mask, queue n frames
  task automatic fade_phase(logic [3:0] mask, curve_t c, frames_t len, logic [23:0] stp,
                            logic [2:0] act, int n, bit corners, bit press);
    frame_t f;
    wait_idle();
    if (mask[REG_CURVE])    write_reg(REG_CURVE, 24'(c));
    if (mask[REG_LENGTH])   write_reg(REG_LENGTH, len);
    if (mask[REG_STEP])     write_reg(REG_STEP, stp);
    if (mask[REG_CHANNELS]) write_reg(REG_CHANNELS, 24'(act));
    @(negedge clk);
    if (press) begin
      send_mode = 0;
      stall_mode = 0;
      hold_request = 1'b1;
    end else begin
      send_mode = $urandom_range(0, 3);
      stall_mode = $urandom_range(0, 3);
    end
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (corners || $urandom_range(0, 9) == 0) begin
          f.old_s[i] = CORNERS[(k + i) % 6];
          f.new_s[i] = CORNERS[(k + i + 3 + $urandom_range(0, 1)) % 6];
        end else begin
          f.old_s[i] = 24'($urandom);
          f.new_s[i] = 24'($urandom);
        end
      end
      frame_backlog.insert(frame_backlog.size(), f);
    end
  endtask

  initial begin
    logic [3:0]  mask;
    frames_t     len;
    logic [23:0] stp;
    logic [2:0]  act;
    int          n;
    int          pick;
    bit          first;

    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CURVE;
    cfg_ch.data = '0;
    frame_ch.valid = 1'b0;
    frame_ch.old_sample_0 = '0;
    frame_ch.old_sample_1 = '0;
    frame_ch.old_sample_2 = '0;
    frame_ch.old_sample_3 = '0;
    frame_ch.new_sample_0 = '0;
    frame_ch.new_sample_1 = '0;
    frame_ch.new_sample_2 = '0;
    frame_ch.new_sample_3 = '0;
    mix_ch.ready = 1'b0;
    send_mode = 0;
    stall_mode = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: single-frame fade, then pass-through
    fade_phase(4'b0000, CURVE_LINEAR, 24'd1, 24'h800000, 3'd4, 2, 1'b1, 1'b0);
    // every curve code, including the unused ones, at x = 0 and x = 1/2
    for (int c = 0; c < 8; c++)
      fade_phase(4'b1111, curve_t'(c), 24'd2, 24'h800000, 3'(1 + c % 4), 2, 1'b1, 1'b0);
    // position saturates at 1.0
    fade_phase(4'b1111, CURVE_EQPOW, 24'd3, 24'hFFFFFF, 3'd3, 3, 1'b1, 1'b0);
    // zero length with no active channels
    fade_phase(4'b1111, CURVE_SMOOTH, 24'd0, 24'h000000, 3'd0, 1, 1'b1, 1'b0);
    // channel count above range after the fade
    fade_phase(4'b1000, CURVE_SMOOTH, 24'd0, 24'h000000, 3'd7, 2, 1'b1, 1'b0);

    // long output hold while frames keep coming
    fade_phase(4'b1111, CURVE_EQPOW, 24'd40, 24'h063E70, 3'd4, 30, 1'b0, 1'b1);
    directed_frames = 54;

    first = 1'b1;
    while (random_frames < RANDOM_FRAMES) begin
      pick = $urandom_range(0, 19);
      len = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF :
            (pick == 2) ? 24'($urandom) : 24'($urandom_range(1, 48));
      pick = $urandom_range(0, 9);
      stp = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF :
            (pick == 2) ? 24'($urandom) : (pick == 3) ? 24'h800000 :
            24'(UNITY / (longint'(len) + 1));
      act = ($urandom_range(0, 9) < 6) ? 3'd4 : 3'($urandom_range(0, 7));
      mask[REG_CURVE]    = ($urandom_range(0, 9) < 6);
      mask[REG_LENGTH]   = ($urandom_range(0, 9) < 8);
      mask[REG_STEP]     = ($urandom_range(0, 9) < 6);
      mask[REG_CHANNELS] = ($urandom_range(0, 9) < 5);
      if (first) mask = 4'b1111;
      first = 1'b0;
      n = $urandom_range(8, 40);
      fade_phase(mask, curve_t'($urandom_range(0, 7)), len, stp, act, n, 1'b0, 1'b0);
      random_frames += n;
    end

    wait_idle();
    repeat (60) @(negedge clk);
    if (expected_mixes.size() != 0)
      report($sformatf("%0d results never arrived", expected_mixes.size()));
    $display("frames: %0d accepted (%0d directed, %0d random), %0d results checked",
             frames_taken, directed_frames, random_frames, mixes_checked);
    $display("register writes: %0d, curve codes used %b, mismatches %0d",
             reg_writes, curves_used, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
